### src/npr_pkg.sv
// Shared types, constants and address helpers for the nametable pixel renderer.
// Used by the controller, the datapath and the top level; depends on nothing.
package npr_pkg;

  localparam int unsigned NPR_ADDR_W    = 14;
  localparam int unsigned NPR_MEM_DEPTH = 16384;

  // Fixed video memory map
  localparam logic [NPR_ADDR_W-1:0] NPR_NT_BASE   = 14'h2000;
  localparam logic [NPR_ADDR_W-1:0] NPR_ATTR_OFS  = 14'h03C0;
  localparam logic [NPR_ADDR_W-1:0] NPR_PAL_BASE  = 14'h3F00;
  localparam logic [NPR_ADDR_W-1:0] NPR_PTAB_HIGH = 14'h1000;

  // Item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Configuration register indexes (paddr[2])
  localparam logic REG_MIRROR = 1'b0;
  localparam logic REG_PTABLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAT,
    ST_PAL,
    ST_DONE
  } npr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic mem_write;
    logic fetch_tile;
    logic fetch_pattern;
    logic fetch_palette;
    logic load_out;
  } npr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } npr_stat_t;

  // Map quadrant to nametable 0..3
  function automatic logic [1:0] nt_select(input logic mirror_vert, input logic [1:0] quad);
    nt_select = mirror_vert ? {1'b0, quad[0]} : {quad[1], 1'b0};
  endfunction

  // Tile number address: base + nt*0x400 + ty*32 + tx
  function automatic logic [NPR_ADDR_W-1:0] tile_addr(input logic [1:0] nt,
                                                      input logic [7:0] px,
                                                      input logic [7:0] py);
    tile_addr = NPR_NT_BASE | {2'b00, nt, py[7:3], px[7:3]};
  endfunction

  // Attribute byte address: base + nt*0x400 + 0x3C0 + (ty/4)*8 + tx/4
  function automatic logic [NPR_ADDR_W-1:0] attr_addr(input logic [1:0] nt,
                                                      input logic [7:0] px,
                                                      input logic [7:0] py);
    attr_addr = NPR_NT_BASE | NPR_ATTR_OFS | {2'b00, nt, 4'b0000, py[7:5], px[7:5]};
  endfunction

  // Pattern plane address: base + tile*16 + plane*8 + row
  function automatic logic [NPR_ADDR_W-1:0] pat_addr(input logic ptab_high,
                                                     input logic [7:0] tile,
                                                     input logic plane,
                                                     input logic [2:0] row);
    pat_addr = (ptab_high ? NPR_PTAB_HIGH : '0) | {2'b00, tile, plane, row};
  endfunction

endpackage

### src/npr_ifs.sv
// Valid/ready channel interfaces for the renderer's item and result words.
// Standalone; no package needed.
interface npr_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [13:0] write_address;
  logic [7:0]  write_data;
  logic [1:0]  view_quadrant;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;

  modport source (output valid, opcode, write_address, write_data, view_quadrant,
                  pixel_x, pixel_y, input ready);
  modport sink (input valid, opcode, write_address, write_data, view_quadrant,
                pixel_x, pixel_y, output ready);
endinterface

interface npr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_value;
  logic [3:0] palette_offset;

  modport source (output valid, palette_value, palette_offset, input ready);
  modport sink (input valid, palette_value, palette_offset, output ready);
endinterface

### src/npr_ctrl.sv
// Sequencing FSM for the renderer: accepts words and steps the datapath fetches.
// Depends on npr_pkg for the state, command and status types.
module npr_ctrl
  import npr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_opcode,
  output logic       in_ready,
  output npr_cmd_t   cmd,
  input  npr_stat_t  st
);

  npr_state_t state_r, state_nxt;
  logic       in_fire;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    in_fire   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        in_fire  = in_valid;
        if (in_fire && in_opcode == OP_WRITE) begin
          cmd.mem_write = 1'b1;
        end else if (in_fire) begin
          cmd.fetch_tile = 1'b1;
          state_nxt      = ST_PAT;
        end
      end
      ST_PAT: begin
        cmd.fetch_pattern = 1'b1;
        state_nxt         = ST_PAL;
      end
      ST_PAL: begin
        cmd.fetch_palette = 1'b1;
        state_nxt         = ST_DONE;
      end
      ST_DONE: begin
        // Hold the palette byte until the output register frees up
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_opcode == OP_RENDER |=> state_r == ST_PAT)
    else $error("render word did not start a fetch");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !st.out_free |=> state_r == ST_DONE)
    else $error("result dropped while output stalled");

  a_write_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_write |-> !cmd.fetch_tile && state_nxt == ST_IDLE)
    else $error("write word started a fetch");
`endif

endmodule

### src/npr_dp.sv
// Renderer datapath: video memory with two read ports, fetch registers, output register.
// Depends on npr_pkg for address helpers, command and status types.
module npr_dp
  import npr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  npr_cmd_t        cmd,
  output npr_stat_t       st,
  input  logic            mirror_vert,
  input  logic            ptab_high,
  input  logic [13:0]     write_address,
  input  logic [7:0]      write_data,
  input  logic [1:0]      view_quadrant,
  input  logic [7:0]      pixel_x,
  input  logic [7:0]      pixel_y,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      palette_value,
  output logic [3:0]      palette_offset
);

  logic [7:0]            vmem [NPR_MEM_DEPTH];
  logic [NPR_ADDR_W-1:0] addr_a, addr_b;
  logic                  re_a, re_b;
  logic [7:0]            rdata_a_r, rdata_b_r;
  logic [7:0]            attr_r;
  logic [2:0]            row_r, col_r;
  logic [1:0]            qsel_r;
  logic [3:0]            offset_r;
  logic                  out_valid_r;
  logic [7:0]            out_value_r;
  logic [3:0]            out_offset_r;
  logic [1:0]            nt;
  logic [1:0]            color, pal;
  logic [2:0]            attr_shift;
  logic [3:0]            offset;

  assign nt = nt_select(mirror_vert, view_quadrant);

  // Read address select per fetch step
  always_comb begin
    addr_a = pat_addr(ptab_high, rdata_a_r, 1'b0, row_r);
    addr_b = pat_addr(ptab_high, rdata_a_r, 1'b1, row_r);
    if (cmd.fetch_tile) begin
      addr_a = tile_addr(nt, pixel_x, pixel_y);
      addr_b = attr_addr(nt, pixel_x, pixel_y);
    end else if (cmd.fetch_palette) begin
      addr_a = NPR_PAL_BASE | {10'd0, offset};
    end
  end

  assign re_a = cmd.fetch_tile | cmd.fetch_pattern | cmd.fetch_palette;
  assign re_b = cmd.fetch_tile | cmd.fetch_pattern;

  // Video memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      vmem[write_address] <= write_data;
    end
    if (re_a) begin
      rdata_a_r <= vmem[addr_a];
    end
    if (re_b) begin
      rdata_b_r <= vmem[addr_b];
    end
  end

  // Pixel color from the two planes; bit index 7-col is the complement of col
  assign color = {rdata_b_r[~col_r], rdata_a_r[~col_r]};
  // Attribute quadrant: ty bit1 picks the lower pair, tx bit1 the right one
  assign attr_shift = {qsel_r, 1'b0};
  assign pal        = (color == 2'd0) ? 2'd0 : attr_r[attr_shift +: 2];
  assign offset     = {pal, color};

  // Capture per-pixel fields, the attribute byte and the palette offset
  always_ff @(posedge clk) begin
    if (cmd.fetch_tile) begin
      row_r  <= pixel_y[2:0];
      col_r  <= pixel_x[2:0];
      qsel_r <= {pixel_y[4], pixel_x[4]};
    end
    if (cmd.fetch_pattern) begin
      attr_r <= rdata_b_r;
    end
    if (cmd.fetch_palette) begin
      offset_r <= offset;
    end
  end

  // Output register: load the result word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r  <= rdata_a_r;
      out_offset_r <= offset_r;
    end
  end

  assign st.out_free     = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign palette_value   = out_value_r;
  assign palette_offset  = out_offset_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over an untaken word");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("output valid without a load");
`endif

endmodule

### src/nametable_pixel_renderer.sv
// Top level of the nametable pixel renderer: configuration registers and wiring.
// Depends on npr_pkg, npr_ifs, npr_ctrl and npr_dp.
//
//   channel   | dir | handshake           | word
//   in_chan   | in  | valid/ready         | opcode, write_address, write_data, quadrant, x, y
//   out_chan  | out | valid/ready         | palette_value, palette_offset
//   APB       | in  | psel/penable/pready | mirroring_vertical @0, pattern_table_high @4
//
// A write word is written to memory in the cycle it is accepted. A render word steps
// through accept with the tile and attribute reads, then pattern planes, palette read
// and result load, set by the chain of dependent reads on the two video memory read ports.
// rst_n is synchronous; it clears the FSM, output valid and configuration, not memory.
// The input is refused while a render is in flight; a stalled output holds the last
// step and a finished word waits in the output register while new words are accepted.
module nametable_pixel_renderer
  import npr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  npr_in_if.sink      in_chan,
  npr_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  npr_cmd_t  cmd;
  npr_stat_t st;
  logic      mirror_vert_r;
  logic      ptab_high_r;
  logic      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_vert_r <= 1'b0;
      ptab_high_r   <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MIRROR) begin
        mirror_vert_r <= pwdata[0];
      end else begin
        ptab_high_r <= pwdata[0];
      end
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PTABLE) begin
      prdata[0] = ptab_high_r;
    end else begin
      prdata[0] = mirror_vert_r;
    end
  end

  npr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_chan.ready),
    .cmd       (cmd),
    .st        (st)
  );

  npr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .mirror_vert    (mirror_vert_r),
    .ptab_high      (ptab_high_r),
    .write_address  (in_chan.write_address),
    .write_data     (in_chan.write_data),
    .view_quadrant  (in_chan.view_quadrant),
    .pixel_x        (in_chan.pixel_x),
    .pixel_y        (in_chan.pixel_y),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .palette_value  (out_chan.palette_value),
    .palette_offset (out_chan.palette_offset)
  );

endmodule
